// File: design/bitmap_text_overlay_assert.svh
// ----------------------------------------------------------------------------
// Text overlay assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_TEXT_OVERLAY_ASSERT_SVH
`define BITMAP_TEXT_OVERLAY_ASSERT_SVH

// same-cycle implication
`define BTO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bto_pkg.sv
// ----------------------------------------------------------------------------
// Text overlay package
// Field widths, command and register codes, and fixed constants of the overlay.
// ----------------------------------------------------------------------------
package bto_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned FONT_GLYPHS = 95;
  localparam int unsigned FONT_AW     = 7;
  localparam int unsigned GLYPH_W     = 64;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_CELL  = 2'd1,
    CMD_GLYPH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH_SCALE = 2'd0,
    CFG_BOX_WIDTH   = 2'd1,
    CFG_BOX_HEIGHT  = 2'd2,
    CFG_BYTE_ORDER  = 2'd3
  } cfg_reg_e;

  localparam logic [7:0] GLYPH_R   = 8'd255;
  localparam logic [7:0] GLYPH_G   = 8'd255;
  localparam logic [7:0] GLYPH_B   = 8'd210;
  localparam logic [7:0] GLYPH_A   = 8'd255;
  localparam logic [7:0] BOX_ALPHA = 8'd220;

  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;
  // glyph slot of '?'
  localparam logic [FONT_AW-1:0] FALLBACK_GLYPH = 7'd31;

  // floor(v/3) = (v*2731) >> 13 for v < 8192
  localparam int unsigned DIV3_MUL   = 2731;
  localparam int unsigned DIV3_SHIFT = 13;
  // floor(v/5) = (v*205) >> 10 for v < 1024
  localparam int unsigned DIV5_MUL   = 205;
  localparam int unsigned DIV5_SHIFT = 10;

  localparam logic [COORD_W-1:0] PAD_NARROW = 12'd6;
  localparam logic [COORD_W-1:0] PAD_WIDE   = 12'd7;

endpackage

// File: design/bto_if.sv
// ----------------------------------------------------------------------------
// Text overlay channels
// Valid/ready channels for input items and processed pixels.
// ----------------------------------------------------------------------------
interface bto_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [bto_pkg::COORD_W-1:0]   pixel_x;
  logic [bto_pkg::COORD_W-1:0]   pixel_y;
  logic [bto_pkg::BYTE_W-1:0]    in_byte0;
  logic [bto_pkg::BYTE_W-1:0]    in_byte1;
  logic [bto_pkg::BYTE_W-1:0]    in_byte2;
  logic [bto_pkg::BYTE_W-1:0]    in_byte3;
  logic [2:0]                    cell_row;
  logic [5:0]                    cell_col;
  logic [7:0]                    char_code;
  logic [bto_pkg::FONT_AW-1:0]   glyph_index;
  logic [bto_pkg::GLYPH_W-1:0]   glyph_word;

  modport source (
    output valid, command, pixel_x, pixel_y, in_byte0, in_byte1, in_byte2, in_byte3,
           cell_row, cell_col, char_code, glyph_index, glyph_word,
    input  ready
  );
  modport sink (
    input  valid, command, pixel_x, pixel_y, in_byte0, in_byte1, in_byte2, in_byte3,
           cell_row, cell_col, char_code, glyph_index, glyph_word,
    output ready
  );
endinterface

interface bto_out_if;
  logic                       valid;
  logic                       ready;
  logic [bto_pkg::BYTE_W-1:0] out_byte0;
  logic [bto_pkg::BYTE_W-1:0] out_byte1;
  logic [bto_pkg::BYTE_W-1:0] out_byte2;
  logic [bto_pkg::BYTE_W-1:0] out_byte3;

  modport source (
    output valid, out_byte0, out_byte1, out_byte2, out_byte3,
    input  ready
  );
  modport sink (
    input  valid, out_byte0, out_byte1, out_byte2, out_byte3,
    output ready
  );
endinterface

// File: design/bitmap_text_overlay.sv
// ----------------------------------------------------------------------------
// Bitmap text overlay
// Darkens a box of a pixel stream and draws 8x8 glyphs from a loaded text grid.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries one item per transfer: a pixel pass, a text cell write or a
//   font glyph write. Only a pixel pass produces a transfer on pix_o; cell and
//   glyph writes update the grid and font RAMs in item order.
//   The cfg port (cfg_we_i, cfg_index_i, cfg_data_i) sets scale, box size and
//   byte order; write it only while the block is idle.
// Throughput and pipeline:
//   One item per cycle while pix_o is not stalled and no clearing pass runs.
//   The input transfer loads the first of six registers: input register,
//   scale divide, grid address, grid RAM read, font RAM read, output register.
//   The two RAM read ports set the stage split.
// Reset:
//   Reset clears the valid bits, sets the scale to 1 and clears the other config
//   registers, then a clearing pass writes every text cell to empty, one cell a
//   cycle; pix_i.ready stays low until it ends. Font entries hold no defined
//   value until written.
// Stall:
//   A stalled pix_o holds the output register; bubbles in the pipe still fill,
//   so pix_i keeps taking items until every stage holds one.
// ----------------------------------------------------------------------------
`include "bitmap_text_overlay_assert.svh"

module bitmap_text_overlay #(
  parameter int unsigned TEXT_ROWS = 8,
  parameter int unsigned TEXT_COLS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bto_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bto_pkg::CFG_W-1:0]         cfg_data_i,
  bto_in_if.sink                            pix_i,
  bto_out_if.source                         pix_o
);

  localparam int unsigned GRID_CELLS = TEXT_ROWS * TEXT_COLS;
  localparam int unsigned GRID_AW    = $clog2(GRID_CELLS);
  localparam int unsigned FAW        = bto_pkg::FONT_AW;

  typedef struct packed {
    bto_pkg::cmd_e  cmd;
    logic           in_box;
    logic           ge_pad;
    logic [11:0]    dx;
    logic [11:0]    dy;
    logic [7:0]     byte0;
    logic [7:0]     byte1;
    logic [7:0]     byte2;
    logic [7:0]     byte3;
    logic [2:0]     cell_row;
    logic [5:0]     cell_col;
    logic [7:0]     char_code;
    logic [FAW-1:0] glyph_index;
    logic [63:0]    glyph_word;
  } s1_t;

  typedef struct packed {
    bto_pkg::cmd_e  cmd;
    logic           maybe_glyph;
    logic [11:0]    ux;
    logic [11:0]    uy;
    logic [31:0]    shade;
    logic [2:0]     cell_row;
    logic [5:0]     cell_col;
    logic [7:0]     char_code;
    logic [FAW-1:0] glyph_index;
    logic [63:0]    glyph_word;
  } s2_t;

  typedef struct packed {
    bto_pkg::cmd_e  cmd;
    logic           maybe_glyph;
    logic [8:0]     row;
    logic [8:0]     col;
    logic [5:0]     bit_idx;
    logic [31:0]    shade;
    logic [7:0]     char_code;
    logic [FAW-1:0] glyph_index;
    logic [63:0]    glyph_word;
  } s3_t;

  typedef struct packed {
    bto_pkg::cmd_e  cmd;
    logic           maybe_glyph;
    logic [5:0]     bit_idx;
    logic [31:0]    shade;
    logic [FAW-1:0] glyph_index;
    logic [63:0]    glyph_word;
  } s4_t;

  typedef struct packed {
    logic           glyph_on;
    logic [5:0]     bit_idx;
    logic [31:0]    shade;
  } s5_t;

  // configuration
  logic [1:0]  scale_q;
  logic [11:0] box_w_q;
  logic [11:0] box_h_q;
  logic        bgra_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= 2'd1;
      box_w_q <= '0;
      box_h_q <= '0;
      bgra_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (bto_pkg::cfg_reg_e'(cfg_index_i))
        bto_pkg::CFG_GLYPH_SCALE: scale_q <= cfg_data_i[1:0];
        bto_pkg::CFG_BOX_WIDTH:   box_w_q <= cfg_data_i[11:0];
        bto_pkg::CFG_BOX_HEIGHT:  box_h_q <= cfg_data_i[11:0];
        bto_pkg::CFG_BYTE_ORDER:  bgra_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [1:0]  scale_eff;
  logic [11:0] pad;

  assign scale_eff = (scale_q == 2'd0) ? 2'd1 : scale_q;
  assign pad       = (scale_eff == 2'd3) ? bto_pkg::PAD_WIDE : bto_pkg::PAD_NARROW;

  // grid clearing pass after reset
  logic               clr_active_q;
  logic [GRID_AW-1:0] clr_cnt_q;
  logic               clr_last;

  assign clr_last = (clr_cnt_q == GRID_AW'(GRID_CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
    end else if (clr_active_q) begin
      clr_cnt_q <= clr_cnt_q + GRID_AW'(1);
      if (clr_last) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic en1, en2, en3, en4, en5, en6;
  logic in_xfer;

  assign en6 = !out_valid_q || pix_o.ready;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pix_i.ready = en1 && !clr_active_q;
  assign in_xfer     = pix_i.valid && pix_i.ready;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;

  // stage 1: box and pad tests, offsets from the text origin
  always_comb begin
    s1_d.cmd         = bto_pkg::cmd_e'(pix_i.command);
    s1_d.in_box      = (pix_i.pixel_x < box_w_q) && (pix_i.pixel_y < box_h_q);
    s1_d.ge_pad      = (pix_i.pixel_x >= pad) && (pix_i.pixel_y >= pad);
    s1_d.dx          = pix_i.pixel_x - pad;
    s1_d.dy          = pix_i.pixel_y - pad;
    s1_d.byte0       = pix_i.in_byte0;
    s1_d.byte1       = pix_i.in_byte1;
    s1_d.byte2       = pix_i.in_byte2;
    s1_d.byte3       = pix_i.in_byte3;
    s1_d.cell_row    = pix_i.cell_row;
    s1_d.cell_col    = pix_i.cell_col;
    s1_d.char_code   = pix_i.char_code;
    s1_d.glyph_index = pix_i.glyph_index;
    s1_d.glyph_word  = pix_i.glyph_word;
  end

  // stage 2: offsets divided by scale, box shading
  logic [24:0] dx_prod, dy_prod;
  logic [17:0] p0, p1, p2;

  assign dx_prod = 25'(s1_q.dx) * 25'(bto_pkg::DIV3_MUL);
  assign dy_prod = 25'(s1_q.dy) * 25'(bto_pkg::DIV3_MUL);
  assign p0      = 18'(s1_q.byte0) * 18'(bto_pkg::DIV5_MUL);
  assign p1      = 18'(s1_q.byte1) * 18'(bto_pkg::DIV5_MUL);
  assign p2      = 18'(s1_q.byte2) * 18'(bto_pkg::DIV5_MUL);

  always_comb begin
    case (scale_eff)
      2'd3: begin
        s2_d.ux = dx_prod[bto_pkg::DIV3_SHIFT +: 12];
        s2_d.uy = dy_prod[bto_pkg::DIV3_SHIFT +: 12];
      end
      2'd2: begin
        s2_d.ux = s1_q.dx >> 1;
        s2_d.uy = s1_q.dy >> 1;
      end
      default: begin
        s2_d.ux = s1_q.dx;
        s2_d.uy = s1_q.dy;
      end
    endcase
    s2_d.cmd         = s1_q.cmd;
    s2_d.maybe_glyph = s1_q.in_box && s1_q.ge_pad;
    if (s1_q.in_box) begin
      s2_d.shade = {bto_pkg::BOX_ALPHA,
                    p2[bto_pkg::DIV5_SHIFT +: 8],
                    p1[bto_pkg::DIV5_SHIFT +: 8],
                    p0[bto_pkg::DIV5_SHIFT +: 8]};
    end else begin
      s2_d.shade = {s1_q.byte3, s1_q.byte2, s1_q.byte1, s1_q.byte0};
    end
    s2_d.cell_row    = s1_q.cell_row;
    s2_d.cell_col    = s1_q.cell_col;
    s2_d.char_code   = s1_q.char_code;
    s2_d.glyph_index = s1_q.glyph_index;
    s2_d.glyph_word  = s1_q.glyph_word;
  end

  // stage 3: cell coordinates and bit index
  always_comb begin
    s3_d.cmd         = s2_q.cmd;
    s3_d.maybe_glyph = s2_q.maybe_glyph;
    if (s2_q.cmd == bto_pkg::CMD_CELL) begin
      s3_d.row = 9'(s2_q.cell_row);
      s3_d.col = 9'(s2_q.cell_col);
    end else begin
      s3_d.row = s2_q.uy[11:3];
      s3_d.col = s2_q.ux[11:3];
    end
    s3_d.bit_idx     = {s2_q.uy[2:0], s2_q.ux[2:0]};
    s3_d.shade       = s2_q.shade;
    s3_d.char_code   = s2_q.char_code;
    s3_d.glyph_index = s2_q.glyph_index;
    s3_d.glyph_word  = s2_q.glyph_word;
  end

  // grid RAM access between stages 3 and 4
  logic               hit_grid;
  logic [GRID_AW-1:0] cell_addr;
  logic               grid_we, grid_re;
  logic [GRID_AW-1:0] grid_waddr;
  logic [7:0]         grid_wdata, grid_rdata;

  assign hit_grid  = ({1'b0, s3_q.row} < 10'(TEXT_ROWS)) && ({1'b0, s3_q.col} < 10'(TEXT_COLS));
  assign cell_addr = GRID_AW'(s3_q.row) * GRID_AW'(TEXT_COLS) + GRID_AW'(s3_q.col);

  assign grid_re = en4 && v3_q && (s3_q.cmd == bto_pkg::CMD_PIXEL);

  always_comb begin
    if (clr_active_q) begin
      grid_we    = 1'b1;
      grid_waddr = clr_cnt_q;
      grid_wdata = '0;
    end else begin
      grid_we    = en4 && v3_q && (s3_q.cmd == bto_pkg::CMD_CELL) && hit_grid;
      grid_waddr = cell_addr;
      grid_wdata = s3_q.char_code;
    end
  end

  bto_ram #(
    .WIDTH (8),
    .DEPTH (GRID_CELLS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (grid_re),
    .raddr_i (cell_addr),
    .rdata_o (grid_rdata)
  );

  always_comb begin
    s4_d.cmd         = s3_q.cmd;
    s4_d.maybe_glyph = s3_q.maybe_glyph && hit_grid;
    s4_d.bit_idx     = s3_q.bit_idx;
    s4_d.shade       = s3_q.shade;
    s4_d.glyph_index = s3_q.glyph_index;
    s4_d.glyph_word  = s3_q.glyph_word;
  end

  // font RAM access between stages 4 and 5
  logic           printable;
  logic [FAW-1:0] font_raddr;
  logic           font_we, font_re;
  logic [63:0]    font_rdata;

  assign printable  = (grid_rdata >= bto_pkg::CODE_FIRST) && (grid_rdata <= bto_pkg::CODE_LAST);
  assign font_raddr = printable ? FAW'(grid_rdata - bto_pkg::CODE_FIRST)
                                : bto_pkg::FALLBACK_GLYPH;
  assign font_re    = en5 && v4_q && (s4_q.cmd == bto_pkg::CMD_PIXEL);
  assign font_we    = en5 && v4_q && (s4_q.cmd == bto_pkg::CMD_GLYPH) &&
                      (s4_q.glyph_index < FAW'(bto_pkg::FONT_GLYPHS));

  bto_ram #(
    .WIDTH (bto_pkg::GLYPH_W),
    .DEPTH (bto_pkg::FONT_GLYPHS)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (s4_q.glyph_index),
    .wdata_i (s4_q.glyph_word),
    .re_i    (font_re),
    .raddr_i (font_raddr),
    .rdata_o (font_rdata)
  );

  always_comb begin
    s5_d.glyph_on = s4_q.maybe_glyph && (grid_rdata != 8'd0);
    s5_d.bit_idx  = s4_q.bit_idx;
    s5_d.shade    = s4_q.shade;
  end

  // output stage: glyph color or shaded pixel
  logic        draw;
  logic [31:0] out_d, out_q;

  assign draw = s5_q.glyph_on && font_rdata[s5_q.bit_idx];

  always_comb begin
    if (!draw) begin
      out_d = s5_q.shade;
    end else if (bgra_q) begin
      out_d = {bto_pkg::GLYPH_A, bto_pkg::GLYPH_R, bto_pkg::GLYPH_G, bto_pkg::GLYPH_B};
    end else begin
      out_d = {bto_pkg::GLYPH_A, bto_pkg::GLYPH_B, bto_pkg::GLYPH_G, bto_pkg::GLYPH_R};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_xfer;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      // drop all but pixel items; cell and glyph writes are done by now
      if (en5) v5_q <= v4_q && (s4_q.cmd == bto_pkg::CMD_PIXEL);
      if (en6) out_valid_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
    if (en5) s5_q <= s5_d;
    if (en6) out_q <= out_d;
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.out_byte0 = out_q[7:0];
  assign pix_o.out_byte1 = out_q[15:8];
  assign pix_o.out_byte2 = out_q[23:16];
  assign pix_o.out_byte3 = out_q[31:24];

  `BTO_ASSERT_IMP(a_clr_blocks_input, clr_active_q, !pix_i.ready, "input taken during grid clear")
  `BTO_ASSERT_IMP(a_clr_pipe_empty, clr_active_q, !(v1_q || v2_q || v3_q || v4_q || v5_q || out_valid_q), "pipeline busy during grid clear")
  `BTO_ASSERT_IMP(a_font_wr_range, font_we, s4_q.glyph_index < FAW'(bto_pkg::FONT_GLYPHS), "font write past last glyph")
  `BTO_ASSERT_NXT(a_clr_done, clr_active_q && clr_last, !clr_active_q && pix_i.ready == en1, "grid clear did not finish")

endmodule

// File: design/bto_ram.sv
// ----------------------------------------------------------------------------
// Text overlay RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bto_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Text overlay testbench
// Streams pixel passes, text cell writes and font writes into the overlay
// under several scale, box and byte order settings with varying idle and
// stall patterns, and checks every output pixel against an in-bench model
// of the darkened box and the glyph drawing.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bto_pkg::*;

  localparam int unsigned GRID_ROWS    = 8;
  localparam int unsigned GRID_COLS    = 64;
  localparam int unsigned DARKEN_DIV   = 5;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct {
    cmd_e               command;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [7:0]         b0;
    logic [7:0]         b1;
    logic [7:0]         b2;
    logic [7:0]         b3;
    logic [2:0]         crow;
    logic [5:0]         ccol;
    logic [7:0]         code;
    logic [FONT_AW-1:0] gidx;
    logic [GLYPH_W-1:0] gword;
  } item_t;

  typedef logic [0:3][7:0] pix_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  bto_in_if  pix_in ();
  bto_out_if pix_out ();

  bitmap_text_overlay #(
    .TEXT_ROWS(GRID_ROWS),
    .TEXT_COLS(GRID_COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_in),
    .pix_o      (pix_out)
  );

  // overlay state mirror
  logic [7:0]         grid_mirror [GRID_ROWS*GRID_COLS];
  logic [GLYPH_W-1:0] font_mirror [FONT_GLYPHS];
  logic [1:0]         cfg_scale;
  logic [11:0]        box_w;
  logic [11:0]        box_h;
  logic               cfg_bgra;

  item_t       item_q[$];
  pix_t        pixel_exp_q[$];
  item_t       cur_item;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_cnt = 0;
  int unsigned pixel_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic pix_t overlay_pixel(item_t it);
    int unsigned s, pad, csz, dx, dy, crow, ccol, bitn;
    logic [7:0]         code;
    logic [FONT_AW-1:0] idx;
    logic               lit;
    pix_t               p;
    p   = {it.b0, it.b1, it.b2, it.b3};
    lit = 1'b0;
    if (it.px >= box_w || it.py >= box_h) return p;
    s   = (cfg_scale == 2'd0) ? 1 : cfg_scale;
    pad = (4 + s < 6) ? 6 : ((4 + s > 14) ? 14 : 4 + s);
    csz = 8 * s;
    if (it.px >= pad && it.py >= pad) begin
      dx   = it.px - pad;
      dy   = it.py - pad;
      ccol = dx / csz;
      crow = dy / csz;
      if (crow < GRID_ROWS && ccol < GRID_COLS) begin
        code = grid_mirror[crow * GRID_COLS + ccol];
        if (code != 8'd0) begin
          if (code < CODE_FIRST || code > CODE_LAST) idx = FALLBACK_GLYPH;
          else idx = FONT_AW'(code - CODE_FIRST);
          bitn = ((dy % csz) / s) * 8 + (dx % csz) / s;
          lit  = font_mirror[idx][bitn];
        end
      end
    end
    if (lit) begin
      p = cfg_bgra ? {GLYPH_B, GLYPH_G, GLYPH_R, GLYPH_A} : {GLYPH_R, GLYPH_G, GLYPH_B, GLYPH_A};
    end else begin
      p = {8'(it.b0 / DARKEN_DIV), 8'(it.b1 / DARKEN_DIV), 8'(it.b2 / DARKEN_DIV), BOX_ALPHA};
    end
    return p;
  endfunction

  function automatic void accept_item(item_t it);
    case (it.command)
      CMD_CELL: begin
        if (it.crow < GRID_ROWS && it.ccol < GRID_COLS)
          grid_mirror[it.crow * GRID_COLS + it.ccol] = it.code;
      end
      CMD_GLYPH: begin
        if (it.gidx < FONT_GLYPHS) font_mirror[it.gidx] = it.gword;
      end
      CMD_PIXEL: pixel_exp_q.push_back(overlay_pixel(it));
      default: ;
    endcase
  endfunction

  function automatic void check_pixel();
    pix_t got, want;
    bit   bad;
    got = {pix_out.out_byte0, pix_out.out_byte1, pix_out.out_byte2, pix_out.out_byte3};
    pixel_cnt++;
    if (pixel_exp_q.size() == 0) begin
      note_failure($sformatf("pixel %0d: unexpected transfer %h", pixel_cnt, got));
      return;
    end
    want = pixel_exp_q.pop_front();
    bad  = 1'b0;
    for (int k = 0; k < 4; k++) if (got[k] !== want[k]) bad = 1'b1;
    if (bad)
      note_failure($sformatf("pixel %0d: expected %h %h %h %h, got %h %h %h %h", pixel_cnt,
                             want[0], want[1], want[2], want[3], got[0], got[1], got[2], got[3]));
  endfunction

  // stimulus builders
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_code();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel < 8) return 8'($urandom_range(CODE_FIRST, CODE_LAST));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t rand_item(cmd_e c);
    item_t it;
    it.command = c;
    it.px      = COORD_W'($urandom);
    it.py      = COORD_W'($urandom);
    it.b0      = 8'($urandom);
    it.b1      = 8'($urandom);
    it.b2      = 8'($urandom);
    it.b3      = 8'($urandom);
    it.crow    = 3'($urandom);
    it.ccol    = 6'($urandom);
    it.code    = 8'($urandom);
    it.gidx    = FONT_AW'($urandom);
    it.gword   = {$urandom, $urandom};
    return it;
  endfunction

  function automatic void push_cell(int unsigned row, int unsigned col, logic [7:0] code);
    item_t it;
    it      = rand_item(CMD_CELL);
    it.crow = 3'(row);
    it.ccol = 6'(col);
    it.code = code;
    item_q.push_back(it);
  endfunction

  function automatic void push_glyph(int unsigned idx, logic [GLYPH_W-1:0] word);
    item_t it;
    it       = rand_item(CMD_GLYPH);
    it.gidx  = FONT_AW'(idx);
    it.gword = word;
    item_q.push_back(it);
  endfunction

  // fill < 0 gives random bytes
  function automatic void push_pixel(int unsigned x, int unsigned y, int fill);
    item_t it;
    it    = rand_item(CMD_PIXEL);
    it.px = COORD_W'(x);
    it.py = COORD_W'(y);
    it.b0 = (fill < 0) ? rand_byte() : 8'(fill);
    it.b1 = (fill < 0) ? rand_byte() : 8'(fill);
    it.b2 = (fill < 0) ? rand_byte() : 8'(fill);
    it.b3 = (fill < 0) ? rand_byte() : 8'(fill);
    item_q.push_back(it);
  endfunction

  function automatic int unsigned rand_coord(int unsigned reach, int unsigned lim);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4095);
      1: return $urandom_range(lim == 0 ? 0 : lim - 1, lim >= 4095 ? 4095 : lim + 1);
      default: return $urandom_range(0, reach);
    endcase
  endfunction

  // write one cell, sometimes its glyph too, then sweep pixels across it
  function automatic int unsigned queue_text_burst();
    int unsigned s, pad, csz, row, col, npx, n;
    logic [7:0] code;
    s    = (cfg_scale == 2'd0) ? 1 : cfg_scale;
    pad  = (4 + s < 6) ? 6 : 4 + s;
    csz  = 8 * s;
    row  = $urandom_range(0, GRID_ROWS - 1);
    col  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, GRID_COLS - 1) : $urandom_range(0, 7);
    code = rand_code();
    push_cell(row, col, code);
    n = 1;
    if ($urandom_range(0, 3) == 0) begin
      if (code >= CODE_FIRST && code <= CODE_LAST) push_glyph(code - CODE_FIRST, {$urandom, $urandom});
      else push_glyph(FALLBACK_GLYPH, {$urandom, $urandom});
      n++;
    end
    npx = $urandom_range(4, 12);
    repeat (npx)
      push_pixel(pad + col * csz + $urandom_range(0, csz - 1),
                 pad + row * csz + $urandom_range(0, csz - 1), -1);
    return n + npx;
  endfunction

  function automatic void queue_random(int unsigned n);
    int unsigned cnt, sel, csz;
    item_t it;
    cnt = 0;
    csz = 8 * ((cfg_scale == 2'd0) ? 1 : cfg_scale);
    while (cnt < n) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        cnt += queue_text_burst();
      end else if (sel < 85) begin
        push_pixel(rand_coord(GRID_COLS * csz + 24, box_w), rand_coord(GRID_ROWS * csz + 24, box_h), -1);
        cnt++;
      end else if (sel < 92) begin
        if ($urandom_range(0, 7) == 0) push_glyph($urandom_range(FONT_GLYPHS, 127), {$urandom, $urandom});
        else push_glyph($urandom_range(0, FONT_GLYPHS - 1), {$urandom, $urandom});
        cnt++;
      end else if (sel < 97) begin
        push_cell($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1), rand_code());
        cnt++;
      end else begin
        it = rand_item(CMD_NONE);
        item_q.push_back(it);
        cnt++;
      end
    end
  endfunction

  // every font entry gets a value before any cell can point at it
  function automatic void queue_font_load();
    for (int i = 0; i < FONT_GLYPHS; i++) begin
      case (i % 16)
        0: push_glyph(i, '1);
        1: push_glyph(i, '0);
        default: push_glyph(i, {$urandom, $urandom});
      endcase
    end
  endfunction

  // scale 1, pad 6, full box, RGBA
  function automatic void queue_directed();
    item_t it;
    push_glyph(33, 64'hFF81_8181_8181_81FF);
    push_glyph(94, '1);
    push_glyph(FALLBACK_GLYPH, 64'h00FF_00FF_00FF_00FF);
    push_glyph(127, '1);
    push_glyph(FONT_GLYPHS, '0);
    push_cell(0, 0, 8'd65);
    push_cell(0, 1, 8'd127);
    push_cell(0, 2, 8'd255);
    push_cell(0, 63, CODE_LAST);
    push_cell(7, 63, 8'd31);
    push_pixel(0, 0, 255);
    push_pixel(4095, 4095, 0);
    push_pixel(6, 6, -1);
    push_pixel(7, 7, -1);
    push_pixel(6, 14, -1);
    push_pixel(14, 6, -1);
    push_pixel(22, 13, -1);
    push_pixel(517, 13, -1);
    push_pixel(510, 62, -1);
    push_pixel(518, 6, -1);
    push_pixel(6, 70, -1);
    push_pixel(5, 10, -1);
    push_pixel(4094, 4094, -1);
    it = rand_item(CMD_NONE);
    item_q.push_back(it);
  endfunction

  task automatic settle();
    do @(negedge clk_i);
    while (item_q.size() != 0 || pix_in.valid || pixel_exp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_reg_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_GLYPH_SCALE: cfg_scale = val[1:0];
      CFG_BOX_WIDTH:   box_w     = val;
      CFG_BOX_HEIGHT:  box_h     = val;
      CFG_BYTE_ORDER:  cfg_bgra  = val[0];
      default: ;
    endcase
  endtask

  task automatic set_mode(logic [1:0] scale, int unsigned bw, int unsigned bh, logic bgra,
                          int unsigned sidle, int unsigned rstall);
    settle();
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    cfg_write(CFG_GLYPH_SCALE, {10'($urandom), scale});
    cfg_write(CFG_BOX_WIDTH, CFG_W'(bw));
    cfg_write(CFG_BOX_HEIGHT, CFG_W'(bh));
    cfg_write(CFG_BYTE_ORDER, {11'($urandom), bgra});
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAIL bitmap_text_overlay");
      $finish;
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
    end else begin
      if (pix_in.valid && pix_in.ready) accept_item(cur_item);
      if (!pix_in.valid || pix_in.ready) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item = item_q.pop_front();
          pix_in.command     <= cur_item.command;
          pix_in.pixel_x     <= cur_item.px;
          pix_in.pixel_y     <= cur_item.py;
          pix_in.in_byte0    <= cur_item.b0;
          pix_in.in_byte1    <= cur_item.b1;
          pix_in.in_byte2    <= cur_item.b2;
          pix_in.in_byte3    <= cur_item.b3;
          pix_in.cell_row    <= cur_item.crow;
          pix_in.cell_col    <= cur_item.ccol;
          pix_in.char_code   <= cur_item.code;
          pix_in.glyph_index <= cur_item.gidx;
          pix_in.glyph_word  <= cur_item.gword;
          pix_in.valid       <= 1'b1;
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) check_pixel();
      pix_out.ready <= (hold_cnt == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_GLYPH_SCALE;
    cfg_data           = '0;
    pix_in.valid       = 1'b0;
    pix_in.command     = CMD_NONE;
    pix_in.pixel_x     = '0;
    pix_in.pixel_y     = '0;
    pix_in.in_byte0    = '0;
    pix_in.in_byte1    = '0;
    pix_in.in_byte2    = '0;
    pix_in.in_byte3    = '0;
    pix_in.cell_row    = '0;
    pix_in.cell_col    = '0;
    pix_in.char_code   = '0;
    pix_in.glyph_index = '0;
    pix_in.glyph_word  = '0;
    pix_out.ready      = 1'b0;
    cfg_scale          = 2'd1;
    box_w              = '0;
    box_h              = '0;
    cfg_bgra           = 1'b0;
    for (int i = 0; i < GRID_ROWS * GRID_COLS; i++) grid_mirror[i] = 8'd0;
    for (int i = 0; i < FONT_GLYPHS; i++) font_mirror[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(2'd1, 4095, 4095, 1'b0, 0, 0);
    queue_font_load();
    queue_directed();
    queue_random(80);
    set_mode(2'd2, 700, 150, 1'b1, 79, 0);
    queue_random(100);
    set_mode(2'd3, 4095, 4095, 1'b0, 0, 79);
    queue_random(100);
    set_mode(2'd0, 350, 70, 1'b1, 36, 36);
    queue_random(100);
    // fill the pipe against a held output, then pause until it drains
    set_mode(2'd2, 4095, 4095, 1'b1, 0, 0);
    hold_req = 1'b1;
    queue_random(40);
    settle();
    queue_random(40);
    set_mode(2'd3, 0, 4095, 1'b0, 36, 36);
    queue_random(20);
    settle();

    if (pixel_exp_q.size() != 0)
      note_failure($sformatf("%0d pixels never arrived", pixel_exp_q.size()));
    if (fail_cnt == 0) begin
      $display("PASS bitmap_text_overlay");
    end else begin
      $display("FAIL bitmap_text_overlay");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/bto_pkg.sv
design/bto_if.sv
design/bto_ram.sv
design/bitmap_text_overlay.sv
tb/sv/tb_top.sv
